// File: rtl/rmc_pkg.sv
`default_nettype none
package rmc_pkg;

  localparam int VAL_W        = 16;
  localparam int PRM_W        = 8;
  localparam int MOD_BITS_DEF = 16;
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_CRT_MODE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MODULUS   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_EXPONENT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRIME_P   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRIME_Q   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EXP_P     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_EXP_Q     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_Q_INVERSE = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_W,
    ST_BIT,
    ST_MUL_W,
    ST_SQ_W,
    ST_M2P_W,
    ST_H_W,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic [VAL_W-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } mm_rsp_t;

endpackage
`default_nettype wire

// File: rtl/rmc_modmul.sv
`default_nettype none
module rmc_modmul
  import rmc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire mm_req_t req,
  output mm_rsp_t      rsp
);

  localparam int DVD_W = 2 * VAL_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [VAL_W-1:0] rem_r, rem_nxt;
  logic [VAL_W-1:0] m_r, m_nxt;
  logic [VAL_W:0]   trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    m_nxt    = m_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, m_r}) begin
        rem_nxt = VAL_W'(trial - {1'b0, m_r});
      end else begin
        rem_nxt = trial[VAL_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.a * req.b;
      rem_nxt  = '0;
      m_nxt    = req.m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    m_r   <= m_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = rem_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("modmul started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == CNT_LAST) |=> (done_r && !busy_r))
    else $error("modmul did not finish after last step");

  a_rem_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < m_r))
    else $error("modmul remainder not below modulus");

endmodule
`default_nettype wire

// File: rtl/rsa_modexp_crt.sv
`default_nettype none
// RSA modular exponentiation, plain or CRT. One shared modular multiplier
// (16x16 product, then a 32-step restoring remainder) does every multiply
// and sets the pace. Plain mode: 1 + N + popcount multiplies, N =
// min(MOD_BITS, 16) exponent bits. CRT mode: two 8-bit exponentiations
// plus a reduction and a multiply for recombination. A zero modulus or
// prime answers with 0. One item at a time; the next input is taken once
// the result sits in the output register.
module rsa_modexp_crt
  import rmc_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0]     cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [VAL_W-1:0]     in_value_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [VAL_W-1:0]          out_value_out
);

  localparam int CNT_W = $clog2(VAL_W + 1);
  localparam logic [CNT_W-1:0] PLAIN_STEPS = CNT_W'((MOD_BITS < VAL_W) ? MOD_BITS : VAL_W);
  localparam logic [CNT_W-1:0] CRT_STEPS   = CNT_W'((MOD_BITS < PRM_W) ? MOD_BITS : PRM_W);

  logic             crt_mode_r;
  logic [VAL_W-1:0] modulus_r, exponent_r;
  logic [PRM_W-1:0] prime_p_r, prime_q_r, exp_p_r, exp_q_r, q_inverse_r;

  state_t           state_r, state_nxt;
  logic             phase_r, phase_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [VAL_W-1:0] mod_r, mod_nxt;
  logic [VAL_W-1:0] exp_r, exp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] acc_r, acc_nxt;
  logic [VAL_W-1:0] sq_r, sq_nxt;
  logic [PRM_W-1:0] m1_r, m1_nxt;
  logic [PRM_W-1:0] m2_r, m2_nxt;
  logic [PRM_W-1:0] h_r, h_nxt;
  logic [VAL_W-1:0] res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;

  logic [CNT_W-1:0]   step_lim;
  logic               in_xfer;
  logic               zero_key;
  logic               pow_done;
  logic [PRM_W:0]     dsum;
  logic [PRM_W-1:0]   diff;
  logic [2*PRM_W-1:0] hq;
  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;

  rmc_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crt_mode_r  <= 1'b0;
      modulus_r   <= VAL_W'(143);
      exponent_r  <= VAL_W'(7);
      prime_p_r   <= PRM_W'(13);
      prime_q_r   <= PRM_W'(11);
      exp_p_r     <= PRM_W'(7);
      exp_q_r     <= PRM_W'(3);
      q_inverse_r <= PRM_W'(6);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CRT_MODE:  crt_mode_r  <= cfg_wdata[0];
        REG_MODULUS:   modulus_r   <= cfg_wdata;
        REG_EXPONENT:  exponent_r  <= cfg_wdata;
        REG_PRIME_P:   prime_p_r   <= cfg_wdata[PRM_W-1:0];
        REG_PRIME_Q:   prime_q_r   <= cfg_wdata[PRM_W-1:0];
        REG_EXP_P:     exp_p_r     <= cfg_wdata[PRM_W-1:0];
        REG_EXP_Q:     exp_q_r     <= cfg_wdata[PRM_W-1:0];
        REG_Q_INVERSE: q_inverse_r <= cfg_wdata[PRM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign step_lim = crt_mode_r ? CRT_STEPS : PLAIN_STEPS;
  assign pow_done = (cnt_r == step_lim);
  assign zero_key = crt_mode_r ? (prime_p_r == '0 || prime_q_r == '0) : (modulus_r == '0);

  // (m1 - m2 mod p) mod p, both operands already below p
  assign dsum = {1'b0, m1_r} + {1'b0, prime_p_r} - {1'b0, mm_rsp.result[PRM_W-1:0]};
  assign diff = (dsum >= {1'b0, prime_p_r}) ? PRM_W'(dsum - {1'b0, prime_p_r})
                                            : dsum[PRM_W-1:0];
  assign hq   = h_r * prime_q_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = zero_key ? ST_OUT : ST_RED;
      end
      ST_RED:   state_nxt = ST_RED_W;
      ST_RED_W: if (mm_rsp.done) state_nxt = ST_BIT;
      ST_BIT: begin
        if (pow_done) begin
          if (!crt_mode_r)   state_nxt = ST_OUT;
          else if (!phase_r) state_nxt = ST_RED;
          else               state_nxt = ST_M2P_W;
        end else begin
          state_nxt = exp_r[0] ? ST_MUL_W : ST_SQ_W;
        end
      end
      ST_MUL_W: if (mm_rsp.done) state_nxt = ST_SQ_W;
      ST_SQ_W:  if (mm_rsp.done) state_nxt = ST_BIT;
      ST_M2P_W: if (mm_rsp.done) state_nxt = ST_H_W;
      ST_H_W:   if (mm_rsp.done) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    val_nxt       = val_r;
    mod_nxt       = mod_r;
    exp_nxt       = exp_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    h_nxt         = h_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    mm_req        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          val_nxt   = in_value_in;
          phase_nxt = 1'b0;
          res_nxt   = '0;
          if (crt_mode_r) begin
            mod_nxt = VAL_W'(prime_p_r);
            exp_nxt = VAL_W'(exp_p_r);
          end else begin
            mod_nxt = modulus_r;
            exp_nxt = exponent_r;
          end
        end
      end
      ST_RED: begin
        mm_req.start = 1'b1;
        mm_req.a     = val_r;
        mm_req.b     = VAL_W'(1);
        mm_req.m     = mod_r;
        acc_nxt      = (mod_r == VAL_W'(1)) ? '0 : VAL_W'(1);
        cnt_nxt      = '0;
      end
      ST_RED_W: if (mm_rsp.done) sq_nxt = mm_rsp.result;
      ST_BIT: begin
        if (pow_done) begin
          if (!crt_mode_r) begin
            res_nxt = acc_r;
          end else if (!phase_r) begin
            m1_nxt    = acc_r[PRM_W-1:0];
            phase_nxt = 1'b1;
            mod_nxt   = VAL_W'(prime_q_r);
            exp_nxt   = VAL_W'(exp_q_r);
          end else begin
            m2_nxt       = acc_r[PRM_W-1:0];
            mm_req.start = 1'b1;
            mm_req.a     = acc_r;
            mm_req.b     = VAL_W'(1);
            mm_req.m     = VAL_W'(prime_p_r);
          end
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = exp_r[0] ? acc_r : sq_r;
          mm_req.b     = sq_r;
          mm_req.m     = mod_r;
        end
      end
      ST_MUL_W: begin
        if (mm_rsp.done) begin
          acc_nxt      = mm_rsp.result;
          mm_req.start = 1'b1;
          mm_req.a     = sq_r;
          mm_req.b     = sq_r;
          mm_req.m     = mod_r;
        end
      end
      ST_SQ_W: begin
        if (mm_rsp.done) begin
          sq_nxt  = mm_rsp.result;
          exp_nxt = exp_r >> 1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_M2P_W: begin
        if (mm_rsp.done) begin
          mm_req.start = 1'b1;
          mm_req.a     = VAL_W'(q_inverse_r);
          mm_req.b     = VAL_W'(diff);
          mm_req.m     = VAL_W'(prime_p_r);
        end
      end
      ST_H_W: if (mm_rsp.done) h_nxt = mm_rsp.result[PRM_W-1:0];
      ST_FIN: res_nxt = VAL_W'(hq) + VAL_W'(m2_r);
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r       <= val_nxt;
    mod_r       <= mod_nxt;
    exp_r       <= exp_nxt;
    acc_r       <= acc_nxt;
    sq_r        <= sq_nxt;
    m1_r        <= m1_nxt;
    m2_r        <= m2_nxt;
    h_r         <= h_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BIT) |-> (cnt_r <= step_lim))
    else $error("exponent bit counter past limit");

  a_h_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (h_r < prime_p_r))
    else $error("CRT coefficient not reduced modulo p");

endmodule
`default_nettype wire

// File: verif/rsa_modexp_crt_check.sv
`timescale 1ns / 1ps
module rsa_modexp_crt_check
  import rmc_pkg::*;
#(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [VAL_W-1:0]     in_value_in,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [VAL_W-1:0]     out_value_out,
  output int                   fails,
  output int                   outstanding,
  output int                   results_seen
);

  logic             crt_mode;
  logic [VAL_W-1:0] modulus;
  logic [VAL_W-1:0] exponent;
  logic [PRM_W-1:0] prime_p;
  logic [PRM_W-1:0] prime_q;
  logic [PRM_W-1:0] exp_p;
  logic [PRM_W-1:0] exp_q;
  logic [PRM_W-1:0] q_inverse;
  logic [VAL_W-1:0] expected_values[$];
  logic [VAL_W-1:0] want;

  function automatic longint unsigned pow_mod(input longint unsigned base,
                                              input longint unsigned e,
                                              input longint unsigned m);
    longint unsigned acc;
    longint unsigned sq;
    int i;
    acc = 1 % m;
    sq = base % m;
    for (i = 0; i < MOD_BITS && i < 64; i++) begin
      if (e[i]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return acc;
  endfunction

  function automatic logic [VAL_W-1:0] expected_power(input logic [VAL_W-1:0] v);
    longint unsigned m1;
    longint unsigned m2;
    longint unsigned diff;
    longint unsigned h;
    longint unsigned r;
    r = 0;
    if (!crt_mode) begin
      if (modulus != 0) r = pow_mod(64'(v), 64'(exponent), 64'(modulus));
    end else if (prime_p != 0 && prime_q != 0) begin
      m1 = pow_mod(64'(v), 64'(exp_p), 64'(prime_p));
      m2 = pow_mod(64'(v), 64'(exp_q), 64'(prime_q));
      diff = (m1 + prime_p - (m2 % prime_p)) % prime_p;
      h = (q_inverse * diff) % prime_p;
      r = m2 + h * prime_q;
    end
    return r[VAL_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      crt_mode = 1'b0;
      modulus = 16'd143;
      exponent = 16'd7;
      prime_p = 8'd13;
      prime_q = 8'd11;
      exp_p = 8'd7;
      exp_q = 8'd3;
      q_inverse = 8'd6;
      expected_values.delete();
      fails <= 0;
      outstanding <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_values.size() == 0) begin
          $display("%0t: value_out %h transferred with nothing expected", $time,
                   out_value_out);
          fails <= fails + 1;
        end else begin
          want = expected_values.pop_front();
          if (out_value_out !== want) begin
            $display("%0t: value_out expected %h actual %h", $time, want, out_value_out);
            fails <= fails + 1;
          end
        end
      end
      if (in_valid && in_ready) expected_values.push_back(expected_power(in_value_in));
      if (cfg_we) begin
        case (cfg_index)
          REG_CRT_MODE:  crt_mode = cfg_wdata[0];
          REG_MODULUS:   modulus = cfg_wdata;
          REG_EXPONENT:  exponent = cfg_wdata;
          REG_PRIME_P:   prime_p = cfg_wdata[PRM_W-1:0];
          REG_PRIME_Q:   prime_q = cfg_wdata[PRM_W-1:0];
          REG_EXP_P:     exp_p = cfg_wdata[PRM_W-1:0];
          REG_EXP_Q:     exp_q = cfg_wdata[PRM_W-1:0];
          REG_Q_INVERSE: q_inverse = cfg_wdata[PRM_W-1:0];
          default: ;
        endcase
      end
      outstanding <= expected_values.size();
    end
  end

endmodule

// File: verif/rsa_modexp_crt_test.sv
`timescale 1ns / 1ps
module rsa_modexp_crt_test;
  import rmc_pkg::*;

  localparam int NUM_PHASES      = 26;
  localparam int ITEMS_PER_PHASE = 20;
  localparam int HOLD_CYCLES     = 2500;
  localparam int TAIL_CYCLES     = 1200;
  localparam int WATCHDOG_LIMIT  = 20000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [VAL_W-1:0]     in_value_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VAL_W-1:0]     out_value_out;

  int fails;
  int outstanding;
  int results_seen;
  int items_sent = 0;
  int settings = 0;
  int crt_settings = 0;
  int stall_cycles = 0;
  bit calm = 1'b0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;

  rsa_modexp_crt u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_out (out_value_out)
  );

  rsa_modexp_crt_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value_out (out_value_out),
    .fails         (fails),
    .outstanding   (outstanding),
    .results_seen  (results_seen)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, stall_cycles);
      $display("rsa_modexp_crt_test NOT OK");
      $finish;
    end
  end

  initial begin : result_side
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        n = HOLD_CYCLES;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 18);
      end else begin
        out_ready <= 1'b1;
        n = $urandom_range(1, 30);
      end
      repeat (n) @(posedge clk);
    end
  end

  task automatic send_value(input logic [VAL_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    in_value_in <= v;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    gap = 0;
    if (!calm && !steady && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // writes all eight registers; unused upper data bits carry noise
  task automatic apply_setting(input logic crt, input logic [VAL_W-1:0] modv,
                               input logic [VAL_W-1:0] expv, input logic [PRM_W-1:0] p,
                               input logic [PRM_W-1:0] q, input logic [PRM_W-1:0] ep,
                               input logic [PRM_W-1:0] eq, input logic [PRM_W-1:0] qi);
    logic [VAL_W-1:0] data [8];
    logic [VAL_W-1:0] junk;
    int i;
    junk = VAL_W'($urandom);
    data[REG_CRT_MODE] = {junk[VAL_W-1:1], crt};
    data[REG_MODULUS] = modv;
    data[REG_EXPONENT] = expv;
    junk = VAL_W'($urandom);
    data[REG_PRIME_P] = {junk[VAL_W-1:PRM_W], p};
    junk = VAL_W'($urandom);
    data[REG_PRIME_Q] = {junk[VAL_W-1:PRM_W], q};
    junk = VAL_W'($urandom);
    data[REG_EXP_P] = {junk[VAL_W-1:PRM_W], ep};
    junk = VAL_W'($urandom);
    data[REG_EXP_Q] = {junk[VAL_W-1:PRM_W], eq};
    junk = VAL_W'($urandom);
    data[REG_Q_INVERSE] = {junk[VAL_W-1:PRM_W], qi};
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[REG_IDX_W-1:0];
      cfg_wdata <= data[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
    if (crt) crt_settings++;
  endtask

  initial begin : stimulus
    int primes[$] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59,
                      61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127,
                      131, 137, 139, 149, 151, 157, 163, 167, 173, 179, 181, 191, 193,
                      197, 199, 211, 223, 227, 229, 233, 239, 241, 251};
    int corner_mods[5] = '{0, 1, 2, 3, 65535};
    int corner_exps[4] = '{0, 1, 65535, 32768};
    int phase;
    int kind;
    int pick;
    int i;
    int j;
    int k;
    int n;
    int p;
    int q;
    int ep;
    int eq;
    int qi;
    int top_val;
    logic crt;
    logic [VAL_W-1:0] modv;
    logic [VAL_W-1:0] expv;
    logic [VAL_W-1:0] v;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key: plain mode, 143, exponent 7
    send_value(16'h0000);
    send_value(16'h0001);
    send_value(16'd142);
    send_value(16'd143);
    send_value(16'hFFFF);
    send_value(16'h5555);
    drain_results();
    apply_setting(1'b0, 16'd0, 16'h1234, 8'd13, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'hBEEF);
    drain_results();
    apply_setting(1'b0, 16'd1, 16'd0, 8'd13, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'h0007);
    drain_results();
    apply_setting(1'b0, 16'hFFFF, 16'd0, 8'd13, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'hFFFF);
    send_value(16'h0000);
    drain_results();
    apply_setting(1'b0, 16'hFFFF, 16'hFFFF, 8'd13, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'hFFFF);
    send_value(16'hFFFE);
    send_value(16'h8000);
    drain_results();
    apply_setting(1'b0, 16'd2, 16'hFFFF, 8'd13, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'h0003);
    drain_results();
    apply_setting(1'b1, 16'd143, 16'd7, 8'd13, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'h0000);
    send_value(16'h0001);
    send_value(16'd142);
    send_value(16'hFFFF);
    send_value(16'h0017);
    drain_results();
    apply_setting(1'b1, 16'd143, 16'd7, 8'd0, 8'd11, 8'd7, 8'd3, 8'd6);
    send_value(16'h0005);
    drain_results();
    apply_setting(1'b1, 16'd143, 16'd7, 8'd13, 8'd0, 8'd7, 8'd3, 8'd6);
    send_value(16'h0005);
    drain_results();
    apply_setting(1'b1, 16'd0, 16'd0, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254);
    send_value(16'hFFFF);
    send_value(16'h1357);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      calm = (phase >= NUM_PHASES - 3);
      steady = (phase == 2);
      kind = $urandom_range(0, 9);
      crt = 1'b0;
      modv = VAL_W'($urandom);
      expv = VAL_W'($urandom);
      p = $urandom_range(0, 255);
      q = $urandom_range(0, 255);
      ep = $urandom_range(0, 255);
      eq = $urandom_range(0, 255);
      qi = $urandom_range(0, 255);
      if (kind < 4) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) modv = VAL_W'(corner_mods[$urandom_range(0, 4)]);
        else if (pick < 3) modv = VAL_W'($urandom_range(2, 255));
        else modv = VAL_W'($urandom_range(2, 65535));
        if ($urandom_range(0, 4) == 0) expv = VAL_W'(corner_exps[$urandom_range(0, 3)]);
        top_val = int'(modv);
      end else if (kind < 8) begin
        // consistent CRT key from two distinct primes
        crt = 1'b1;
        i = $urandom_range(0, primes.size() - 1);
        do j = $urandom_range(0, primes.size() - 1); while (j == i);
        p = primes[i];
        q = primes[j];
        ep = $urandom_range(0, p - 2);
        eq = $urandom_range(0, q - 2);
        qi = 0;
        for (k = 1; k < p; k++) begin
          if ((q * k) % p == 1) qi = k;
        end
        top_val = p * q;
      end else begin
        crt = 1'b1;
        if ($urandom_range(0, 3) == 0) p = $urandom_range(0, 1);
        if ($urandom_range(0, 3) == 0) q = $urandom_range(0, 1);
        top_val = p * q;
      end
      apply_setting(crt, modv, expv, PRM_W'(p), PRM_W'(q), PRM_W'(ep), PRM_W'(eq),
                    PRM_W'(qi));
      if (steady) hold_req = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          case ($urandom_range(0, 3))
            0: v = 16'h0000;
            1: v = 16'h0001;
            2: v = 16'hFFFF;
            default: v = VAL_W'(top_val - 1);
          endcase
        end else begin
          v = VAL_W'($urandom);
        end
        send_value(v);
      end
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d values under %0d register settings (%0d CRT), %0d results compared",
             items_sent, settings, crt_settings, results_seen);
    $display("incl. zero and unit moduli, zero primes, full-width exponents, %0d-cycle stall",
             HOLD_CYCLES);
    if (fails == 0) begin
      $display("rsa_modexp_crt_test OK");
    end else begin
      $display("rsa_modexp_crt_test NOT OK");
    end
    $finish;
  end

endmodule
